FILE: design/uuid_v4_text_generator_assert.svh
// ----------------------------------------------------------------------------
// UUID v4 text generator assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef UUID_V4_TEXT_GENERATOR_ASSERT_SVH
`define UUID_V4_TEXT_GENERATOR_ASSERT_SVH

// same-cycle implication
`define UVTG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("uvtg assertion failed");

// next-cycle implication
`define UVTG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("uvtg assertion failed");

`endif

FILE: design/uvtg_pkg.sv
// ----------------------------------------------------------------------------
// UUID v4 text generator package
// Types, constants and the hex character encoder shared by the block.
// ----------------------------------------------------------------------------
package uvtg_pkg;

    localparam int unsigned UUID_LEN = 36;
    localparam int unsigned POS_W    = 6;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned HEX_W    = 128;

    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [7:0]        t_char;

    localparam t_word LCG_MUL   = 32'd1664525;
    localparam t_word LCG_ADD   = 32'd1013904223;
    localparam t_word SEED_INIT = 32'h1234_5678;

    localparam t_pos POS_DASH0 = 6'd8;
    localparam t_pos POS_DASH1 = 6'd13;
    localparam t_pos POS_DASH2 = 6'd18;
    localparam t_pos POS_DASH3 = 6'd23;
    localparam t_pos POS_LAST  = 6'd35;

    localparam t_char CHAR_DASH = 8'h2d;
    localparam t_char CHAR_ZERO = 8'h30;
    localparam t_char CHAR_A    = 8'h61;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GEN,
        ST_EMIT
    } t_gen_state;

    function automatic t_char hex_char(input logic [3:0] nib);
        t_char c;
        if (nib < 4'd10) begin
            c = CHAR_ZERO + {4'd0, nib};
        end else begin
            c = CHAR_A + {4'd0, nib - 4'd10};
        end
        return c;
    endfunction

endpackage

FILE: design/uvtg_front.sv
// ----------------------------------------------------------------------------
// UUID v4 text generator front end
// Accepts request items, drops empty ones and queues the rest as a count.
// ----------------------------------------------------------------------------
module uvtg_front #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic i_request,
    output logic o_pending,
    input  logic i_pop
);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             push;
    logic             pop;

    assign o_in_stall = (r_count == CNT_FULL);
    assign o_pending  = (r_count != '0);
    assign push       = i_in_valid && !o_in_stall && i_request;
    assign pop        = i_pop && o_pending;

    always_comb begin
        case ({push, pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

FILE: design/uvtg_back.sv
// ----------------------------------------------------------------------------
// UUID v4 text generator back end
// Steps the LCG four times per job, then emits 36 characters one per cycle unless stalled.
// ----------------------------------------------------------------------------
module uvtg_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  uvtg_pkg::t_word i_cfg_wdata,
    input  logic           i_pending,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output uvtg_pkg::t_char o_out_char,
    output uvtg_pkg::t_pos  o_char_position,
    output logic           o_last_char
);
    import uvtg_pkg::*;

    t_gen_state          r_fsm;
    t_gen_state          n_fsm;
    t_word               r_seed;
    t_word               r_lcg;
    logic                r_seeded;
    logic [1:0]          r_step;
    logic [3*WORD_W-1:0] r_words;
    logic [HEX_W-1:0]    r_hex;
    t_pos                r_pos;
    logic                r_out_valid;
    t_char               r_out_char;
    t_pos                r_out_pos;
    logic                r_out_last;

    t_word               lcg_base;
    t_word               lcg_next;
    logic [HEX_W-1:0]    all_words;
    logic [HEX_W-1:0]    hex_fmt;
    logic                out_free;
    logic                is_dash;
    t_char               cur_char;
    logic                gen_step;
    logic                emit_load;

    assign lcg_base  = r_seeded ? r_lcg : r_seed;
    assign lcg_next  = lcg_base * LCG_MUL + LCG_ADD;
    assign all_words = {r_words, lcg_next};
    assign hex_fmt   = {all_words[127:96],
                        all_words[95:80], 4'h4, all_words[75:64],
                        2'b10, all_words[45:32],
                        all_words[63:48], all_words[31:0]};
    assign out_free  = !r_out_valid || !i_out_stall;
    assign is_dash   = (r_pos == POS_DASH0) || (r_pos == POS_DASH1) ||
                       (r_pos == POS_DASH2) || (r_pos == POS_DASH3);
    assign cur_char  = is_dash ? CHAR_DASH : hex_char(r_hex[HEX_W-1 -: 4]);

    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            ST_IDLE: begin
                if (i_pending) n_fsm = ST_GEN;
            end
            ST_GEN: begin
                if (r_step == 2'd3) n_fsm = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free && r_pos == POS_LAST) n_fsm = ST_IDLE;
            end
            default: n_fsm = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        gen_step  = 1'b0;
        emit_load = 1'b0;
        unique case (r_fsm)
            ST_IDLE: o_pop     = i_pending;
            ST_GEN:  gen_step  = 1'b1;
            ST_EMIT: emit_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= ST_IDLE;
            r_seed      <= SEED_INIT;
            r_lcg       <= '0;
            r_seeded    <= 1'b0;
            r_step      <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm <= n_fsm;
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            if (gen_step) begin
                r_lcg    <= lcg_next;
                r_seeded <= 1'b1;
                r_step   <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_pos <= '0;
                end
            end
            if (emit_load) begin
                r_out_valid <= 1'b1;
                r_pos       <= r_pos + POS_W'(1);
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (gen_step) begin
            r_words <= {r_words[2*WORD_W-1:0], lcg_next};
            if (r_step == 2'd3) begin
                r_hex <= hex_fmt;
            end
        end
        if (emit_load) begin
            r_out_char <= cur_char;
            r_out_pos  <= r_pos;
            r_out_last <= (r_pos == POS_LAST);
            if (!is_dash) begin
                r_hex <= {r_hex[HEX_W-5:0], 4'h0};
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_char      = r_out_char;
    assign o_char_position = r_out_pos;
    assign o_last_char     = r_out_last;

endmodule

FILE: design/uuid_v4_text_generator.sv
// ----------------------------------------------------------------------------
// UUID v4 text generator
// Turns each request into a 36-character lower-case version-4 UUID string
// drawn from a 32-bit linear congruential generator.
// ----------------------------------------------------------------------------
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+-----------------------------------
// in       | i_in_valid   | o_in_stall   | i_request
// out      | o_out_valid  | i_out_stall  | o_out_char, o_char_position,
//          |              |              | o_last_char
// cfg      | i_cfg_we     | -            | i_cfg_wdata (seed)
//
// Each identifier pops the queue, takes 4 generator steps through the
// single multiply-add, then leaves as 36 characters at one per cycle from
// the output register while not stalled. Requests of 0 are dropped.
// The front holds QUEUE_DEPTH items and stalls its input while full.
// Synchronous active-low reset; the seed returns to 0x12345678 and is
// loaded on the first request. Output stalls hold the character stream.
// ----------------------------------------------------------------------------
`include "uuid_v4_text_generator_assert.svh"

module uuid_v4_text_generator #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_request,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_char,
    output logic [5:0]  o_char_position,
    output logic        o_last_char
);
    import uvtg_pkg::*;

    logic job_pending;
    logic job_pop;

    uvtg_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_request  (i_request),
        .o_pending  (job_pending),
        .i_pop      (job_pop)
    );

    uvtg_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_pending       (job_pending),
        .o_pop           (job_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_char      (o_out_char),
        .o_char_position (o_char_position),
        .o_last_char     (o_last_char)
    );

    `UVTG_ASSERT_IMP(a_last_pos, o_out_valid,
        o_last_char == (o_char_position == POS_LAST))
    `UVTG_ASSERT_IMP(a_dash_pos, o_out_valid && (o_char_position == POS_DASH2),
        o_out_char == CHAR_DASH)
    `UVTG_ASSERT_NXT(a_pos_step, o_out_valid && !i_out_stall && !o_last_char,
        !o_out_valid || (o_char_position == $past(o_char_position) + 6'd1))
    `UVTG_ASSERT_IMP(a_pop_pending, job_pop, job_pending)

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// UUID v4 text generator testbench
// Drives identifier requests, some of them zero, through the valid/stall
// input channel and checks every character of every identifier against a
// predictor that keeps its own generator state and seed register. The seed
// is written between phases, both before and after the generator is seeded.
// Both channels idle at random in bursts; the last phase runs without gaps.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int DRAIN_CYCLES   = 100;
    localparam int PHASE_REQUESTS = 100;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        uvtg_pkg::t_char ch;
        uvtg_pkg::t_pos  pos;
        logic            last;
    } t_uuid_char;

    class uuid_scoreboard;
        uvtg_pkg::t_word seed_reg;
        uvtg_pkg::t_word lcg_state;
        bit              seeded;
        t_uuid_char      expected_chars[$];
        int              mismatches;

        function new();
            seed_reg   = uvtg_pkg::SEED_INIT;
            lcg_state  = '0;
            seeded     = 1'b0;
            mismatches = 0;
        endfunction

        function void write_seed(uvtg_pkg::t_word value);
            seed_reg = value;
        endfunction

        function uvtg_pkg::t_word lcg_advance();
            lcg_state = lcg_state * uvtg_pkg::LCG_MUL + uvtg_pkg::LCG_ADD;
            return lcg_state;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        function void note_request(logic request);
            uvtg_pkg::t_word w1, w2, w3, w4;
            logic [127:0]    digits;
            logic [3:0]      nib;
            int              nib_idx;
            t_uuid_char      c;
            if (!request) return;
            if (!seeded) begin
                lcg_state = seed_reg;
                seeded    = 1'b1;
            end
            w1 = lcg_advance();
            w2 = lcg_advance();
            w3 = lcg_advance();
            w4 = lcg_advance();
            digits = {w1, w2[31:16], 4'h4, w2[11:0], 2'b10, w3[13:0], w3[31:16], w4};
            nib_idx = 0;
            for (int k = 0; k < uvtg_pkg::UUID_LEN; k++) begin
                c.pos  = uvtg_pkg::t_pos'(k);
                c.last = (c.pos == uvtg_pkg::POS_LAST);
                if (c.pos == uvtg_pkg::POS_DASH0 || c.pos == uvtg_pkg::POS_DASH1 ||
                    c.pos == uvtg_pkg::POS_DASH2 || c.pos == uvtg_pkg::POS_DASH3) begin
                    c.ch = uvtg_pkg::CHAR_DASH;
                end else begin
                    nib = digits[127 - 4 * nib_idx -: 4];
                    nib_idx++;
                    if (nib < 4'd10) begin
                        c.ch = uvtg_pkg::CHAR_ZERO + {4'd0, nib};
                    end else begin
                        c.ch = uvtg_pkg::CHAR_A + {4'd0, nib - 4'd10};
                    end
                end
                expected_chars.push_back(c);
            end
        endfunction

        function void check_char(uvtg_pkg::t_char ch, uvtg_pkg::t_pos pos, logic last);
            t_uuid_char want;
            if (expected_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("tb: unexpected char %h pos %0d last %b", ch, pos, last);
                return;
            end
            want = expected_chars.pop_front();
            if (want.ch !== ch || want.pos !== pos || want.last !== last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("tb: mismatch expected char %h pos %0d last %b, got char %h pos %0d last %b",
                             want.ch, want.pos, want.last, ch, pos, last);
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_in_valid  = 1'b0;
    logic        i_request   = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_out_char;
    logic [5:0]  o_char_position;
    logic        o_last_char;

    uuid_scoreboard sb;
    bit             sender_idle_en = 1'b0;
    bit             stall_en       = 1'b0;

    uuid_v4_text_generator i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_request       (i_request),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_char      (o_out_char),
        .o_char_position (o_char_position),
        .o_last_char     (o_last_char)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_char(o_out_char, o_char_position, o_last_char);
            if (i_in_valid && !o_in_stall)
                sb.note_request(i_request);
            if (i_cfg_we)
                sb.write_seed(i_cfg_wdata);
        end
    end

    initial begin
        forever begin
            if (stall_en && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            @(posedge i_clk);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                i_cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    task automatic write_seed(logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic push_request(logic request);
        i_in_valid <= 1'b1;
        i_request  <= request;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic sender_gap();
        if (sender_idle_en && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic run_phase(int requests, int pause_at);
        int   issued;
        logic request;
        issued = 0;
        while (issued < requests) begin
            request = ($urandom_range(0, 9) != 0);
            push_request(request);
            if (request) issued++;
            if (request && issued == pause_at) begin
                wait_drained();
            end else begin
                sender_gap();
            end
        end
    endtask

    initial begin
        logic directed_reqs[$];
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // last write before the first request wins
        write_seed(32'hffff_ffff);
        case ($urandom_range(0, 2))
            0: write_seed(32'h0000_0000);
            1: write_seed(32'hffff_ffff);
            default: write_seed($urandom);
        endcase

        directed_reqs = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        foreach (directed_reqs[i]) push_request(directed_reqs[i]);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // seed writes after seeding must leave the sequence alone
        write_seed(32'h0000_0000);
        push_request(1'b1);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_seed(32'hffff_ffff);
        push_request(1'b1);
        push_request(1'b0);
        push_request(1'b1);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        for (int phase = 0; phase < 4; phase++) begin
            sender_idle_en = (phase == 1 || phase == 2);
            stall_en       = (phase == 0 || phase == 1);
            write_seed($urandom);
            run_phase(PHASE_REQUESTS, (phase == 1) ? PHASE_REQUESTS / 2
                                                   : $urandom_range(1, PHASE_REQUESTS));
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end

        stall_en = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: uuid_v4_text_generator.f
+incdir+design
design/uvtg_pkg.sv
design/uvtg_front.sv
design/uvtg_back.sv
design/uuid_v4_text_generator.sv
tb/tb_top.sv
